### design/lpfr_pkg.sv
// Shared types and default constants for the LRU page frame replacer.
package lpfr_pkg;

  localparam int DEF_FRAMES    = 4;
  localparam int DEF_PAGE_BITS = 20;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } ctl_state_t;

  typedef struct packed {
    logic update_state;
    logic load_result;
  } dp_cmd_t;

endpackage

### design/lpfr_ctrl.sv
// Handshake controller for the LRU page frame replacer result register.
module lpfr_ctrl
  import lpfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;
  logic       take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (in_tvalid) begin
          state_nxt = ST_FULL;
        end
      end
      ST_FULL: begin
        if (out_tready && !in_tvalid) begin
          state_nxt = ST_EMPTY;
        end
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_EMPTY: begin
        in_tready = 1'b1;
      end
      ST_FULL: begin
        in_tready  = out_tready;
        out_tvalid = 1'b1;
      end
      default: begin
        in_tready  = 1'b0;
        out_tvalid = 1'b0;
      end
    endcase
  end

  assign take             = in_tvalid && in_tready;
  assign cmd.update_state = take;
  assign cmd.load_result  = take;

  // An accepted request always leaves a result waiting in the next cycle.
  a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_tvalid)
    else $error("accepted request produced no result");

endmodule

### design/lpfr_datapath.sv
// Frame tags, valid bits, recency ranks and result register of the replacer.
module lpfr_datapath
  import lpfr_pkg::*;
#(
  parameter int FRAMES    = DEF_FRAMES,
  parameter int PAGE_BITS = DEF_PAGE_BITS,
  parameter int IDX_W     = $clog2(FRAMES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  input  logic [PAGE_BITS-1:0] page,
  output logic                 res_hit,
  output logic [IDX_W-1:0]     res_frame_index,
  output logic                 res_evicted_valid,
  output logic [PAGE_BITS-1:0] res_evicted_page
);

  logic [PAGE_BITS-1:0] page_r [FRAMES];
  logic [FRAMES-1:0]    valid_r;
  logic [IDX_W-1:0]     rank_r [FRAMES];
  logic [IDX_W-1:0]     rank_nxt [FRAMES];

  logic                 lookup_hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 any_empty;
  logic [IDX_W-1:0]     empty_idx;
  logic [IDX_W-1:0]     lru_idx;
  logic [IDX_W-1:0]     target;
  logic [IDX_W-1:0]     old_rank;
  logic                 evict;

  always_comb begin
    lookup_hit = 1'b0;
    hit_idx    = '0;
    any_empty  = 1'b0;
    empty_idx  = '0;
    lru_idx    = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (valid_r[i] && (page_r[i] == page)) begin
        lookup_hit = 1'b1;
        hit_idx    = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        any_empty = 1'b1;
        empty_idx = IDX_W'(i);
      end
      if (rank_r[i] == '0) begin
        lru_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (lookup_hit) begin
      target = hit_idx;
    end else if (any_empty) begin
      target = empty_idx;
    end else begin
      target = lru_idx;
    end
  end

  assign evict    = !lookup_hit && !any_empty;
  assign old_rank = rank_r[target];

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (IDX_W'(i) == target) begin
        rank_nxt[i] = IDX_W'(FRAMES - 1);
      end else if (rank_r[i] > old_rank) begin
        rank_nxt[i] = rank_r[i] - 1'b1;
      end else begin
        rank_nxt[i] = rank_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i] <= IDX_W'(i);
      end
    end else if (cmd.update_state) begin
      rank_r <= rank_nxt;
      if (!lookup_hit) begin
        valid_r[target] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update_state && !lookup_hit) begin
      page_r[target] <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_hit           <= lookup_hit;
      res_frame_index   <= target;
      res_evicted_valid <= evict;
      res_evicted_page  <= evict ? page_r[target] : '0;
    end
  end

  // A hit never changes which frames are occupied.
  a_hit_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update_state && lookup_hit) |=> $stable(valid_r))
    else $error("hit changed frame occupancy");

  // An eviction is only reported when every frame was occupied.
  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_result && any_empty) |=> !res_evicted_valid)
    else $error("eviction reported while a frame was empty");

  // The frame just touched holds the most recent rank.
  a_target_top_rank: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update_state |=> (rank_r[res_frame_index] == IDX_W'(FRAMES - 1)))
    else $error("touched frame is not most recent");

endmodule

### design/lru_page_frame_replacer_core.sv
// Top level of the LRU page frame replacer: controller plus datapath.
//
// Each request on the in_ stream carries one page number. The block looks
// it up in a fully associative set of FRAMES frames and returns one result
// on the out_ stream: hit flag, frame index, and the evicted page if a
// resident page had to be replaced. Empty frames are filled lowest first;
// when all are occupied the least recently used frame is replaced.
// The result is presented in the cycle after its request is accepted. The
// tag compare, frame choice and rank update all finish in the accept cycle,
// so one request is taken per cycle, set by the single result register.
// When the receiver stalls, the result is held and a new request is taken
// only in the cycle that the held result is taken.
// Reset empties all frames and sets the rank of frame i to i; it takes
// effect at once with no sweep.
module lru_page_frame_replacer_core
  import lpfr_pkg::*;
#(
  parameter int FRAMES    = DEF_FRAMES,
  parameter int PAGE_BITS = DEF_PAGE_BITS,
  parameter int IDX_W     = $clog2(FRAMES),
  parameter int IN_W      = ((PAGE_BITS + 7) / 8) * 8,
  parameter int OUT_W     = ((PAGE_BITS + IDX_W + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // Fields from bit 0 up: page_number.
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // Fields from bit 0 up: hit, frame_index, evicted_valid, evicted_page.
  output logic [OUT_W-1:0] out_tdata
);

  dp_cmd_t              cmd;
  logic                 res_hit;
  logic [IDX_W-1:0]     res_frame_index;
  logic                 res_evicted_valid;
  logic [PAGE_BITS-1:0] res_evicted_page;

  lpfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  lpfr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .page              (in_tdata[PAGE_BITS-1:0]),
    .res_hit           (res_hit),
    .res_frame_index   (res_frame_index),
    .res_evicted_valid (res_evicted_valid),
    .res_evicted_page  (res_evicted_page)
  );

  assign out_tdata = OUT_W'({res_evicted_page, res_evicted_valid, res_frame_index, res_hit});

endmodule
